// ===== rtl/core/ipbs_pkg.sv =====
// Shared types and constants for the IR proximity brightness sweep.
// Holds the sweep phase encoding, config and result records, and the level table.
// No dependencies.
`default_nettype none

package ipbs_pkg;

  localparam int RX_SLOTS  = 3;
  localparam int TABLE_LEN = 6;
  localparam int DLY_W     = 10;
  localparam int CMP_W     = 9;
  localparam int WRAP_W    = 16;
  localparam int HIT_W     = 3;

  localparam logic [2:0]       LAST_IDX = 3'(TABLE_LEN - 1);
  localparam logic [HIT_W-1:0] HIT_MAX  = '1;

  localparam logic [CMP_W-1:0] LEVEL_TABLE [TABLE_LEN] = '{
    9'd12, 9'd39, 9'd81, 9'd137, 9'd210, 9'd296
  };

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SENSOR_MASK = 2'd0,
    CFG_ON_DELAY    = 2'd1,
    CFG_OFF_DELAY   = 2'd2,
    CFG_CMP_WRAP    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRE_OFF   = 3'd1,
    PH_LEFT_ON   = 3'd2,
    PH_LEFT_OFF  = 3'd3,
    PH_RIGHT_ON  = 3'd4,
    PH_RIGHT_OFF = 3'd5
  } phase_t;

  typedef struct packed {
    logic [RX_SLOTS-1:0] sensor_mask;
    logic [DLY_W-1:0]    on_delay;
    logic [DLY_W-1:0]    off_delay;
    logic [WRAP_W-1:0]   compare_wrap;
  } cfg_t;

  typedef struct packed {
    logic [CMP_W-1:0]                   left_compare;
    logic [CMP_W-1:0]                   right_compare;
    logic                               busy;
    logic                               done;
    logic [RX_SLOTS-1:0][HIT_W-1:0]     left_hits;
    logic [RX_SLOTS-1:0][HIT_W-1:0]     right_hits;
  } res_t;

  // Table level for a step, clamped to the carrier wrap. Table entries stay
  // below 512, so a clamped value always fits the compare width.
  function automatic logic [CMP_W-1:0] drive_level(input logic [2:0] level,
                                                   input logic [WRAP_W-1:0] wrap);
    logic [2:0]       idx;
    logic [CMP_W-1:0] lv;
    idx = (level > LAST_IDX) ? LAST_IDX : level;
    lv  = LEVEL_TABLE[idx];
    if ({{(WRAP_W-CMP_W){1'b0}}, lv} > wrap) begin
      lv = wrap[CMP_W-1:0];
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ipbs_sweep_ctrl.sv =====
// Sweep sequencer: phase, level, delay counter and hit counters.
// Computes the result of each accepted tick combinationally. Uses ipbs_pkg.
`default_nettype none

module ipbs_sweep_ctrl #(
  parameter int NUM_LEVELS    = 6,
  parameter int NUM_RECEIVERS = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          acc,
  input  wire logic                          action,
  input  wire logic [ipbs_pkg::RX_SLOTS-1:0] rx_low,
  input  wire ipbs_pkg::cfg_t                cfg,
  output ipbs_pkg::res_t                     res
);
  import ipbs_pkg::*;

  phase_t            phase_r, phase_nxt, cur_phase;
  logic [2:0]        level_r, level_nxt, cur_level;
  logic [DLY_W-1:0]  cnt_r, cnt_nxt, cur_cnt, cnt_inc, limit;
  logic [HIT_W-1:0]  lh_r [RX_SLOTS];
  logic [HIT_W-1:0]  rh_r [RX_SLOTS];
  logic [HIT_W-1:0]  lh_nxt [RX_SLOTS];
  logic [HIT_W-1:0]  rh_nxt [RX_SLOTS];
  logic              start_go, lit, last, busy, final_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      level_r <= '0;
      cnt_r   <= '0;
      for (int i = 0; i < RX_SLOTS; i++) begin
        lh_r[i] <= '0;
        rh_r[i] <= '0;
      end
    end else if (acc) begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      cnt_r   <= cnt_nxt;
      for (int i = 0; i < RX_SLOTS; i++) begin
        lh_r[i] <= lh_nxt[i];
        rh_r[i] <= rh_nxt[i];
      end
    end
  end

  always_comb begin
    // A start while idle makes this tick the first dark tick of the sweep
    start_go  = (phase_r == PH_IDLE) && action;
    cur_phase = start_go ? PH_PRE_OFF : phase_r;
    cur_level = start_go ? '0 : level_r;
    cur_cnt   = start_go ? '0 : cnt_r;
    for (int i = 0; i < RX_SLOTS; i++) begin
      lh_nxt[i] = start_go ? '0 : lh_r[i];
      rh_nxt[i] = start_go ? '0 : rh_r[i];
    end

    phase_nxt = cur_phase;
    level_nxt = cur_level;
    cnt_nxt   = cur_cnt;

    lit   = (cur_phase == PH_LEFT_ON) || (cur_phase == PH_RIGHT_ON);
    limit = lit ? cfg.on_delay : cfg.off_delay;
    if (limit == '0) begin
      limit = DLY_W'(1);
    end
    cnt_inc     = cur_cnt + DLY_W'(1);
    last        = (cnt_inc >= limit) || (cnt_inc == '0);
    busy        = (cur_phase != PH_IDLE);
    final_level = (({1'b0, cur_level} + 4'd1) >= 4'(NUM_LEVELS)) || (cur_level == 3'd7);

    res      = '0;
    res.busy = busy;

    if (busy) begin
      cnt_nxt = cnt_inc;
      if (cur_phase == PH_LEFT_ON) begin
        res.left_compare = drive_level(cur_level, cfg.compare_wrap);
      end
      if (cur_phase == PH_RIGHT_ON) begin
        res.right_compare = drive_level(cur_level, cfg.compare_wrap);
      end
    end

    if (busy && last) begin
      cnt_nxt = '0;
      unique case (cur_phase)
        PH_PRE_OFF:  phase_nxt = PH_LEFT_ON;
        PH_LEFT_ON: begin
          for (int i = 0; i < RX_SLOTS; i++) begin
            if (i < NUM_RECEIVERS && cfg.sensor_mask[i] && rx_low[i] &&
                lh_nxt[i] != HIT_MAX) begin
              lh_nxt[i] = lh_nxt[i] + HIT_W'(1);
            end
          end
          phase_nxt = PH_LEFT_OFF;
        end
        PH_LEFT_OFF: phase_nxt = PH_RIGHT_ON;
        PH_RIGHT_ON: begin
          for (int i = 0; i < RX_SLOTS; i++) begin
            if (i < NUM_RECEIVERS && cfg.sensor_mask[i] && rx_low[i] &&
                rh_nxt[i] != HIT_MAX) begin
              rh_nxt[i] = rh_nxt[i] + HIT_W'(1);
            end
          end
          phase_nxt = PH_RIGHT_OFF;
        end
        PH_RIGHT_OFF: begin
          if (final_level) begin
            res.done  = 1'b1;
            phase_nxt = PH_IDLE;
            level_nxt = '0;
          end else begin
            level_nxt = cur_level + 3'd1;
            phase_nxt = PH_LEFT_ON;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end else if (!busy) begin
      phase_nxt = PH_IDLE;
    end

    // Counts are shown through the current mask
    for (int i = 0; i < RX_SLOTS; i++) begin
      res.left_hits[i]  = cfg.sensor_mask[i] ? lh_nxt[i] : '0;
      res.right_hits[i] = cfg.sensor_mask[i] ? rh_nxt[i] : '0;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.done |=> phase_r == PH_IDLE)
    else $error("sweep did not return to idle after done");

  a_idle_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> level_r == '0 && cnt_r == '0)
    else $error("idle with stale level or delay count");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_IDLE && !action |=> phase_r == PH_IDLE)
    else $error("left idle without a start request");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, level_r} < 4'(NUM_LEVELS))
    else $error("level index beyond configured level count");

endmodule

`default_nettype wire

// ===== rtl/core/ipbs_out_buf.sv =====
// Two-entry result buffer (output register plus skid register).
// Keeps input acceptance free of the output stall path. Uses ipbs_pkg.
`default_nettype none

module ipbs_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire ipbs_pkg::res_t res,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ipbs_pkg::res_t      out_res
);
  import ipbs_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_free;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // drain the skid entry first; no request is taken while it is full
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = acc;
        out_nxt       = res;
      end
    end else if (acc) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_park_in_skid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && acc |=> skid_valid_r)
    else $error("request accepted under stall was not parked");

  a_no_acc_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !acc)
    else $error("request accepted with buffer full");

endmodule

`default_nettype wire

// ===== rtl/core/ir_proximity_brightness_sweep.sv =====
// IR proximity brightness sweep: one request per tick, one result per request.
// Results are registered in a two-entry buffer that absorbs output stall.
// Throughput: one request per cycle while its skid entry is empty.
// Reset (rst_n low, synchronous): sweep idle, hit counts zero, buffer empty,
// registers at mask 0, on delay 250, off delay 321, compare wrap 699.
`default_nettype none

module ir_proximity_brightness_sweep #(
  parameter int NUM_LEVELS    = 6,
  parameter int NUM_RECEIVERS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [2:0]  in_receiver_low,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [8:0]       out_left_compare,
  output logic [8:0]       out_right_compare,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [2:0]       out_left_hits_s0,
  output logic [2:0]       out_left_hits_s1,
  output logic [2:0]       out_left_hits_s2,
  output logic [2:0]       out_right_hits_s0,
  output logic [2:0]       out_right_hits_s1,
  output logic [2:0]       out_right_hits_s2
);
  import ipbs_pkg::*;

  cfg_t cfg_r;
  res_t res;
  res_t out_res;
  logic acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_mask  <= '0;
      cfg_r.on_delay     <= DLY_W'(250);
      cfg_r.off_delay    <= DLY_W'(321);
      cfg_r.compare_wrap <= WRAP_W'(699);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SENSOR_MASK: cfg_r.sensor_mask  <= cfg_wdata[RX_SLOTS-1:0];
        CFG_ON_DELAY:    cfg_r.on_delay     <= cfg_wdata[DLY_W-1:0];
        CFG_OFF_DELAY:   cfg_r.off_delay    <= cfg_wdata[DLY_W-1:0];
        CFG_CMP_WRAP:    cfg_r.compare_wrap <= cfg_wdata[WRAP_W-1:0];
        default:         cfg_r              <= cfg_r;
      endcase
    end
  end

  assign acc = in_valid && !in_stall;

  ipbs_sweep_ctrl #(
    .NUM_LEVELS    (NUM_LEVELS),
    .NUM_RECEIVERS (NUM_RECEIVERS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .action (in_action),
    .rx_low (in_receiver_low),
    .cfg    (cfg_r),
    .res    (res)
  );

  ipbs_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .res       (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_left_compare  = out_res.left_compare;
  assign out_right_compare = out_res.right_compare;
  assign out_busy_res      = out_res.busy;
  assign out_done_res      = out_res.done;
  assign out_left_hits_s0  = out_res.left_hits[0];
  assign out_left_hits_s1  = out_res.left_hits[1];
  assign out_left_hits_s2  = out_res.left_hits[2];
  assign out_right_hits_s0 = out_res.right_hits[0];
  assign out_right_hits_s1 = out_res.right_hits[1];
  assign out_right_hits_s2 = out_res.right_hits[2];

endmodule

`default_nettype wire

// ===== sim/ipbs_checker.sv =====
// Result checker for the IR proximity brightness sweep: tracks config writes and accepted
// ticks, predicts each tick's result, and compares it with what the block returns.
// Depends on ipbs_pkg for the phase encoding, register indexes, result record and table.
`timescale 1ns / 100ps

module ipbs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [2:0]  in_receiver_low,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [8:0]  out_left_compare,
  input  logic [8:0]  out_right_compare,
  input  logic        out_busy_res,
  input  logic        out_done_res,
  input  logic [2:0]  out_left_hits_s0,
  input  logic [2:0]  out_left_hits_s1,
  input  logic [2:0]  out_left_hits_s2,
  input  logic [2:0]  out_right_hits_s0,
  input  logic [2:0]  out_right_hits_s1,
  input  logic [2:0]  out_right_hits_s2,
  output int          mismatch_count,
  output int          results_owed
);
  import ipbs_pkg::*;

  localparam int SWEEP_LEVELS = 6;

  // Shadow registers
  logic [2:0]  rx_enable;
  logic [9:0]  lit_ticks;
  logic [9:0]  dark_ticks;
  logic [15:0] carrier_wrap;

  // Shadow sweep state
  phase_t      phase;
  logic [2:0]  level;
  logic [9:0]  tick_count;
  logic [2:0]  left_hits  [RX_SLOTS];
  logic [2:0]  right_hits [RX_SLOTS];

  res_t tick_results_q [$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  // Brightness for the current level, clamped to the wrap and the compare width.
  function automatic logic [8:0] emitter_level();
    int idx;
    int lv;
    idx = (level > 3'(TABLE_LEN - 1)) ? TABLE_LEN - 1 : int'(level);
    lv  = int'(LEVEL_TABLE[idx]);
    if (lv > int'(carrier_wrap)) lv = int'(carrier_wrap);
    if (lv > 511) lv = 511;
    return 9'(lv);
  endfunction

  task automatic step_sweep(input logic start, input logic [2:0] rx, output res_t r);
    logic [9:0] span;
    logic       lit;
    logic       last_tick;
    r = '0;
    if (phase == PH_IDLE && start) begin
      for (int i = 0; i < RX_SLOTS; i++) begin
        left_hits[i]  = '0;
        right_hits[i] = '0;
      end
      phase      = PH_PRE_OFF;
      level      = '0;
      tick_count = '0;
    end
    if (phase != PH_IDLE) begin
      lit  = (phase == PH_LEFT_ON) || (phase == PH_RIGHT_ON);
      span = lit ? lit_ticks : dark_ticks;
      if (span == 0) span = 10'd1;
      r.busy     = 1'b1;
      tick_count = tick_count + 10'd1;
      last_tick  = (tick_count >= span) || (tick_count == 0);
      if (phase == PH_LEFT_ON) r.left_compare = emitter_level();
      else if (phase == PH_RIGHT_ON) r.right_compare = emitter_level();
      if (last_tick) begin
        tick_count = '0;
        case (phase)
          PH_PRE_OFF: phase = PH_LEFT_ON;
          PH_LEFT_ON: begin
            for (int i = 0; i < RX_SLOTS; i++)
              if (rx_enable[i] && rx[i] && left_hits[i] != HIT_MAX)
                left_hits[i] = left_hits[i] + 3'd1;
            phase = PH_LEFT_OFF;
          end
          PH_LEFT_OFF: phase = PH_RIGHT_ON;
          PH_RIGHT_ON: begin
            for (int i = 0; i < RX_SLOTS; i++)
              if (rx_enable[i] && rx[i] && right_hits[i] != HIT_MAX)
                right_hits[i] = right_hits[i] + 3'd1;
            phase = PH_RIGHT_OFF;
          end
          default: begin
            if (int'(level) + 1 >= SWEEP_LEVELS || level >= 3'd7) begin
              r.done = 1'b1;
              phase  = PH_IDLE;
              level  = '0;
            end else begin
              level = level + 3'd1;
              phase = PH_LEFT_ON;
            end
          end
        endcase
      end
    end
    // Counts are shown through the mask as it stands now
    for (int i = 0; i < RX_SLOTS; i++) begin
      r.left_hits[i]  = rx_enable[i] ? left_hits[i]  : 3'd0;
      r.right_hits[i] = rx_enable[i] ? right_hits[i] : 3'd0;
    end
  endtask

  task automatic check_field(input string fname, input int want, input int seen);
    if (want != seen) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, fname, want, seen);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t seen;
    if (!rst_n) begin
      rx_enable    = '0;
      lit_ticks    = 10'd250;
      dark_ticks   = 10'd321;
      carrier_wrap = 16'd699;
      phase        = PH_IDLE;
      level        = '0;
      tick_count   = '0;
      for (int i = 0; i < RX_SLOTS; i++) begin
        left_hits[i]  = '0;
        right_hits[i] = '0;
      end
      tick_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.left_compare  = out_left_compare;
        seen.right_compare = out_right_compare;
        seen.busy          = out_busy_res;
        seen.done          = out_done_res;
        seen.left_hits[0]  = out_left_hits_s0;
        seen.left_hits[1]  = out_left_hits_s1;
        seen.left_hits[2]  = out_left_hits_s2;
        seen.right_hits[0] = out_right_hits_s0;
        seen.right_hits[1] = out_right_hits_s1;
        seen.right_hits[2] = out_right_hits_s2;
        if (tick_results_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual busy=%0d done=%0d",
                   $time, seen.busy, seen.done);
          mismatch_count++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("left_compare", want.left_compare, seen.left_compare);
          check_field("right_compare", want.right_compare, seen.right_compare);
          check_field("busy_res", want.busy, seen.busy);
          check_field("done_res", want.done, seen.done);
          check_field("left_hits_s0", want.left_hits[0], seen.left_hits[0]);
          check_field("left_hits_s1", want.left_hits[1], seen.left_hits[1]);
          check_field("left_hits_s2", want.left_hits[2], seen.left_hits[2]);
          check_field("right_hits_s0", want.right_hits[0], seen.right_hits[0]);
          check_field("right_hits_s1", want.right_hits[1], seen.right_hits[1]);
          check_field("right_hits_s2", want.right_hits[2], seen.right_hits[2]);
        end
      end
      if (in_valid && !in_stall) begin
        step_sweep(in_action, in_receiver_low, want);
        tick_results_q.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SENSOR_MASK: rx_enable    = cfg_wdata[2:0];
          CFG_ON_DELAY:    lit_ticks    = cfg_wdata[9:0];
          CFG_OFF_DELAY:   dark_ticks   = cfg_wdata[9:0];
          CFG_CMP_WRAP:    carrier_wrap = cfg_wdata;
          default: ;
        endcase
      end
    end
    results_owed = tick_results_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the IR proximity brightness sweep bench: clock, reset, tick requests and config
// writes, random input gaps and output stalls, watchdog and verdict.
// Depends on ipbs_pkg, the block ir_proximity_brightness_sweep and ipbs_checker.
`timescale 1ns / 100ps

module testbench;
  import ipbs_pkg::*;

  localparam int TICK_TARGET = 1900;
  localparam int QUIET_FROM  = 1650;
  localparam int STALL_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [2:0]  in_receiver_low = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  out_left_compare, out_right_compare;
  logic        out_busy_res, out_done_res;
  logic [2:0]  out_left_hits_s0, out_left_hits_s1, out_left_hits_s2;
  logic [2:0]  out_right_hits_s0, out_right_hits_s1, out_right_hits_s2;

  int   mismatch_count;
  int   results_owed;
  int   ticks_sent = 0;
  int   idle_cycles = 0;
  logic send_gaps = 1'b0;
  logic recv_gaps = 1'b0;

  always #5 clk = ~clk;

  ir_proximity_brightness_sweep uut (.*);

  ipbs_checker u_checker (.*);

  // Throttle the result side in bursts while enabled
  initial begin
    forever begin
      @(negedge clk);
      if (recv_gaps && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Call at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_tick(input logic act, input logic [2:0] rx);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_receiver_low <= rx;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write only with no request in flight
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'($urandom_range(20, 60));
    return 16'($urandom_range(1, 5));
  endfunction

  function automatic logic [15:0] pick_wrap();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 300));
      2: return 16'd511;
      3: return 16'd512;
      4: return 16'hFFFF;
      5: return 16'd699;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: plain tick, start, start while busy is dropped
    send_tick(1'b0, 3'd7);
    send_tick(1'b1, 3'd0);
    send_tick(1'b1, 3'd7);
    send_tick(1'b0, 3'd0);
    // Longest dark wait, then cut it short mid-wait
    write_reg(CFG_OFF_DELAY, 16'd1023);
    send_tick(1'b0, 3'd5);
    send_tick(1'b0, 3'd2);
    write_reg(CFG_OFF_DELAY, 16'd0);
    send_tick(1'b0, 3'd0);
    // Left emitter lit: longest lit wait, wrap of zero, all receivers on
    write_reg(CFG_ON_DELAY, 16'd1023);
    write_reg(CFG_SENSOR_MASK, 16'd7);
    write_reg(CFG_CMP_WRAP, 16'd0);
    send_tick(1'b0, 3'd7);
    send_tick(1'b0, 3'd7);
    write_reg(CFG_ON_DELAY, 16'd0);
    write_reg(CFG_CMP_WRAP, 16'hFFFF);
    send_tick(1'b0, 3'd7);
    // Mask change between the two sides
    write_reg(CFG_SENSOR_MASK, 16'd5);
    send_tick(1'b0, 3'd1);
    send_tick(1'b0, 3'd7);
    write_reg(CFG_ON_DELAY, 16'd1);
    write_reg(CFG_OFF_DELAY, 16'd1);
    write_reg(CFG_CMP_WRAP, 16'd100);
    repeat (8) send_tick(1'b0, 3'($urandom_range(0, 7)));

    while (ticks_sent < TICK_TARGET) begin
      if (ticks_sent >= QUIET_FROM) begin
        drain();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end else begin
        send_gaps = ($urandom_range(0, 3) != 0);
        recv_gaps = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 1)) write_reg(CFG_SENSOR_MASK, 16'($urandom_range(0, 7)));
      if ($urandom_range(0, 1)) write_reg(CFG_ON_DELAY, pick_delay());
      if ($urandom_range(0, 1)) write_reg(CFG_OFF_DELAY, pick_delay());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_CMP_WRAP, pick_wrap());
      burst = $urandom_range(40, 160);
      repeat (burst) send_tick($urandom_range(0, 9) == 0, 3'($urandom_range(0, 7)));
    end

    drain();
    repeat (5) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
